/* sv/aes256_block_cipher_macros.svh */
// Assertion macros for the AES-256 block cipher checker.
`ifndef AES256_BLOCK_CIPHER_MACROS_SVH
`define AES256_BLOCK_CIPHER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define AES_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define AES_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* sv/aes_pkg.sv */
// Package: types, constants and byte functions of the AES-256 block cipher.
`timescale 1ns / 1ps
package aes_pkg;
  localparam int KeyWords   = 8;
  localparam int SchedWords = 60;
  localparam int IdxW       = 6;
  localparam bit OpEncrypt  = 1'b0;
  localparam bit OpDecrypt  = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] RegKey3 = 2'd0;
  localparam logic [1:0] RegKey2 = 2'd1;
  localparam logic [1:0] RegKey1 = 2'd2;
  localparam logic [1:0] RegKey0 = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXPAND, ST_LOAD, ST_ROUND, ST_DONE
  } state_t;

  // Control from the sequencer to the round datapath.
  typedef struct packed {
    logic       load;
    logic       init;
    logic       step;
    logic       last;
    logic       dec;
  } round_ctrl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // Multiply by x in GF(2^8).
  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // Substitute each byte of a word.
  function automatic logic [31:0] sbox_word(input logic [31:0] w);
    sbox_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction
endpackage

/* sv/aes_key_sched.sv */
// Key schedule: expands the key into four 15-word round key banks, one word a cycle.
`timescale 1ns / 1ps
module aes_key_sched (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [255:0]               key,
  input  logic                       expand_start,
  output logic                       expand_done,
  input  logic [aes_pkg::IdxW-1:0]   rd_idx,
  output logic [127:0]               rd_key
);
  import aes_pkg::*;

  logic [31:0]     mem_c0 [15];
  logic [31:0]     mem_c1 [15];
  logic [31:0]     mem_c2 [15];
  logic [31:0]     mem_c3 [15];
  logic [IdxW-1:0] wr_idx;
  logic            running;
  logic [31:0]     win [KeyWords];
  logic [31:0]     wr_word;
  logic [31:0]     t;
  logic [7:0]      rcon;

  // Sliding window of the last eight schedule words.
  always_comb begin
    t = win[KeyWords-1];
    rcon = 8'h01 << (wr_idx[5:3] - 3'd1);
    if (wr_idx[2:0] == 3'd0) begin
      t = sbox_word({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
    end else if (wr_idx[2:0] == 3'd4) begin
      t = sbox_word(t);
    end
    wr_word = (wr_idx < IdxW'(KeyWords)) ? key[255 - 32*wr_idx[2:0] -: 32] : (win[0] ^ t);
  end

  // Expansion sequencer and window.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      wr_idx  <= '0;
    end else if (expand_start) begin
      running <= 1'b1;
      wr_idx  <= '0;
    end else if (running) begin
      wr_idx <= wr_idx + 1'b1;
      if (wr_idx == IdxW'(SchedWords - 1)) begin
        running <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (running) begin
      for (int i = 0; i < KeyWords - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[KeyWords-1] <= wr_word;
    end
  end

  assign expand_done = running && (wr_idx == IdxW'(SchedWords - 1));

  // Round key banks, one per column: word 4*r+c sits in bank c at row r.
  always_ff @(posedge clk) begin
    if (running) begin
      case (wr_idx[1:0])
        2'd0: mem_c0[wr_idx[5:2]] <= wr_word;
        2'd1: mem_c1[wr_idx[5:2]] <= wr_word;
        2'd2: mem_c2[wr_idx[5:2]] <= wr_word;
        default: mem_c3[wr_idx[5:2]] <= wr_word;
      endcase
    end
  end

  // Registered read of one row from every bank; rd_idx is always a multiple of four.
  always_ff @(posedge clk) begin
    rd_key <= {mem_c0[rd_idx[5:2]], mem_c1[rd_idx[5:2]],
               mem_c2[rd_idx[5:2]], mem_c3[rd_idx[5:2]]};
  end
endmodule

/* sv/aes_round.sv */
// Round unit: one shared encrypt or decrypt round applied to the state each cycle that ctrl.step is set.
`timescale 1ns / 1ps
module aes_round (
  input  logic                 clk,
  input  aes_pkg::round_ctrl_t ctrl,
  input  logic [127:0]         block_in,
  input  logic [127:0]         round_key,
  output logic [127:0]         state
);
  import aes_pkg::*;

  logic [7:0]   s  [16];
  logic [7:0]   sh [16];
  logic [7:0]   sb [16];
  logic [7:0]   mx [16];
  logic [7:0]   kx [16];
  logic [7:0]   res [16];
  logic [7:0]   b2, b4, b8;
  logic [7:0]   m2 [16];
  logic [7:0]   m4 [16];
  logic [7:0]   m8 [16];
  logic [127:0] next_state;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = state[127 - 8*i -: 8];
    end
    // Shift rows, forward or inverse, then byte substitution.
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (ctrl.dec) begin
          sh[r + 4*((c + r) % 4)] = s[r + 4*c];
        end else begin
          sh[r + 4*c] = s[r + 4*((c + r) % 4)];
        end
      end
    end
    for (int i = 0; i < 16; i++) begin
      sb[i] = ctrl.dec ? INV_SBOX[sh[i]] : SBOX[sh[i]];
      kx[i] = sb[i] ^ round_key[127 - 8*i -: 8];
    end
    // Mix columns: forward after the key-free part, inverse after key add.
    for (int i = 0; i < 16; i++) begin
      b2 = ctrl.dec ? kx[i] : sb[i];
      m2[i] = xtime(b2);
      b4 = xtime(m2[i]);
      m4[i] = b4;
      b8 = xtime(b4);
      m8[i] = b8;
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        mx[4*c + r] = 8'h00;
        for (int k = 0; k < 4; k++) begin
          case ((k - r + 4) % 4)
            0: mx[4*c+r] ^= ctrl.dec ? (m8[4*c+k] ^ m4[4*c+k] ^ m2[4*c+k])
                                     : m2[4*c+k];
            1: mx[4*c+r] ^= ctrl.dec ? (m8[4*c+k] ^ m2[4*c+k] ^ kx[4*c+k])
                                     : (m2[4*c+k] ^ sb[4*c+k]);
            2: mx[4*c+r] ^= ctrl.dec ? (m8[4*c+k] ^ m4[4*c+k] ^ kx[4*c+k])
                                     : sb[4*c+k];
            default: mx[4*c+r] ^= ctrl.dec ? (m8[4*c+k] ^ kx[4*c+k]) : sb[4*c+k];
          endcase
        end
      end
    end
    for (int i = 0; i < 16; i++) begin
      if (ctrl.dec) begin
        res[i] = ctrl.last ? kx[i] : mx[i];
      end else begin
        res[i] = (ctrl.last ? sb[i] : mx[i]) ^ round_key[127 - 8*i -: 8];
      end
    end
    for (int i = 0; i < 16; i++) begin
      next_state[127 - 8*i -: 8] = res[i];
    end
  end

  // State register: block load, initial key add, or one round.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      state <= block_in;
    end else if (ctrl.init) begin
      state <= state ^ round_key;
    end else if (ctrl.step) begin
      state <= next_state;
    end
  end
endmodule

/* sv/aes256_block_cipher.sv */
// Top level: APB key registers, sequencer, key schedule and round unit.
`timescale 1ns / 1ps
// An accepted block passes through LOAD, ROUND and DONE; key expansion (EXPAND) comes first
// for the first block after reset or after any key write.
// A new block is accepted only in IDLE; the shared round unit does one round a cycle in ROUND.
// Reset (rst, synchronous): key registers clear to zero, schedule marked stale.
// The result is shown for one cycle with done; the receiver cannot stall.
module aes256_block_cipher (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic        opcode,
  input  logic [63:0] block_high,
  input  logic [63:0] block_low,
  output logic        done,
  output logic [63:0] result_high,
  output logic [63:0] result_low
);
  import aes_pkg::*;

  logic [63:0]     key_reg [4];
  logic            schedule_ready;
  state_t          st, st_next;
  logic [3:0]      rnd, rnd_next;
  logic            dec;
  logic [127:0]    blk;
  logic            exp_start, exp_done;
  logic [IdxW-1:0] rd_idx;
  logic [127:0]    rd_key;
  logic [127:0]    state_q;
  round_ctrl_t     ctrl;
  logic            wr_en;
  logic [3:0]      key_rnd;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2:0] == 3'd0);

  // Key registers at byte addresses 0, 8, 16, 24.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) key_reg[i] <= '0;
      schedule_ready <= 1'b0;
    end else begin
      if (wr_en) begin
        key_reg[paddr[4:3]] <= pwdata;
        schedule_ready <= 1'b0;
      end else if (exp_done) begin
        schedule_ready <= 1'b1;
      end
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[4:3])
      RegKey3: prdata = key_reg[0];
      RegKey2: prdata = key_reg[1];
      RegKey1: prdata = key_reg[2];
      RegKey0: prdata = key_reg[3];
      default: prdata = '0;
    endcase
    if (paddr[2:0] != 3'd0) prdata = '0;
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= ST_IDLE;
      rnd <= '0;
    end else begin
      st  <= st_next;
      rnd <= rnd_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      dec <= opcode;
      blk <= {block_high, block_low};
    end
  end

  // Round key for round rnd (encrypt counts up, decrypt down); read in the previous cycle.
  assign key_rnd = dec ? (4'd14 - rnd) : rnd;
  assign rd_idx  = {key_rnd, 2'b00};

  always_comb begin
    st_next   = st;
    rnd_next  = rnd;
    exp_start = 1'b0;
    ctrl      = '0;
    ctrl.dec  = dec;
    unique case (st)
      ST_IDLE: begin
        if (start) begin
          rnd_next = '0;
          if (schedule_ready) begin
            st_next = ST_LOAD;
          end else begin
            st_next   = ST_EXPAND;
            exp_start = 1'b1;
          end
        end
      end
      ST_EXPAND: begin
        if (exp_done) st_next = ST_LOAD;
      end
      ST_LOAD: begin
        ctrl.load = 1'b1;
        st_next   = ST_ROUND;
      end
      ST_ROUND: begin
        // rd_key holds the key of round rnd (read on previous cycle).
        if (rnd == 4'd0) begin
          ctrl.init = 1'b1;
        end else begin
          ctrl.step = 1'b1;
          ctrl.last = (rnd == 4'd14);
        end
        rnd_next = rnd + 4'd1;
        if (rnd == 4'd14) st_next = ST_DONE;
      end
      ST_DONE: begin
        st_next = ST_IDLE;
      end
      default: st_next = ST_IDLE;
    endcase
  end

  // In ROUND the read address leads by one round: use the next round index.
  logic [3:0]      pre_rnd;
  logic [IdxW-1:0] pre_idx;
  assign pre_rnd = (st == ST_ROUND) ? (dec ? (4'd13 - rnd) : (rnd + 4'd1))
                                    : (dec ? 4'd14 : 4'd0);
  assign pre_idx = (st == ST_ROUND && rnd == 4'd14) ? rd_idx : {pre_rnd, 2'b00};

  assign busy = (st != ST_IDLE);
  assign done = (st == ST_DONE);
  assign result_high = state_q[127:64];
  assign result_low  = state_q[63:0];

  aes_key_sched u_sched (
    .clk          (clk),
    .rst          (rst),
    .key          ({key_reg[0], key_reg[1], key_reg[2], key_reg[3]}),
    .expand_start (exp_start),
    .expand_done  (exp_done),
    .rd_idx       (pre_idx),
    .rd_key       (rd_key)
  );

  aes_round u_round (
    .clk       (clk),
    .ctrl      (ctrl),
    .block_in  (blk),
    .round_key (rd_key),
    .state     (state_q)
  );
endmodule

/* sv/aes_checker.sv */
// Port checker for the AES-256 block cipher, bound to the top level.
`timescale 1ns / 1ps
`include "aes256_block_cipher_macros.svh"
module aes_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic pready
);
  `AES_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy, "accepted word must raise busy")
  `AES_ASSERT_IMPL(a_done_busy, clk, rst, done, busy, "done only while busy")
  `AES_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done && !busy, "done is a single pulse")
  `AES_ASSERT_IMPL(a_pready, clk, rst, 1'b1, pready, "pready stays high")
endmodule

bind aes256_block_cipher aes_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .pready(pready)
);
